[rtl/core/x86_prefix_decoder_defines.svh]
`ifndef X86_PREFIX_DECODER_DEFINES_SVH
`define X86_PREFIX_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define XPD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define XPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/xpd_pkg.sv]
package xpd_pkg;

	localparam int unsigned CODE_W    = 8;
	localparam int unsigned SEG_W     = 3;
	localparam int unsigned COUNT_W   = 4;

	localparam logic [COUNT_W-1:0] MAX_PREFIXES = 4'd14;
	localparam logic [COUNT_W-1:0] COUNT_SAT    = '1;

	localparam logic [SEG_W-1:0] SEG_DS = 3'd0;
	localparam logic [SEG_W-1:0] SEG_CS = 3'd1;
	localparam logic [SEG_W-1:0] SEG_ES = 3'd2;
	localparam logic [SEG_W-1:0] SEG_SS = 3'd3;
	localparam logic [SEG_W-1:0] SEG_FS = 3'd4;
	localparam logic [SEG_W-1:0] SEG_GS = 3'd5;

	localparam logic [CODE_W-1:0] BYTE_OPSIZE = 8'h66;
	localparam logic [CODE_W-1:0] BYTE_ADSIZE = 8'h67;
	localparam logic [CODE_W-1:0] BYTE_CS     = 8'h2e;
	localparam logic [CODE_W-1:0] BYTE_DS     = 8'h3e;
	localparam logic [CODE_W-1:0] BYTE_ES     = 8'h26;
	localparam logic [CODE_W-1:0] BYTE_SS     = 8'h36;
	localparam logic [CODE_W-1:0] BYTE_FS     = 8'h64;
	localparam logic [CODE_W-1:0] BYTE_GS     = 8'h65;
	localparam logic [CODE_W-1:0] BYTE_REPNE  = 8'hf2;
	localparam logic [CODE_W-1:0] BYTE_REPE   = 8'hf3;

	typedef enum logic [2:0] {
		PFX_NONE,
		PFX_OPSIZE,
		PFX_ADSIZE,
		PFX_SEG,
		PFX_REPNE,
		PFX_REPE
	} prefix_kind_t;

	typedef struct packed {
		prefix_kind_t     kind;
		logic [SEG_W-1:0] seg;
	} prefix_class_t;

	typedef struct packed {
		logic              valid;
		logic [CODE_W-1:0] code;
	} stage_t;

	function automatic prefix_class_t classify(input logic [CODE_W-1:0] b);
		prefix_class_t c;
		c.kind = PFX_NONE;
		c.seg  = SEG_DS;
		case (b)
			BYTE_OPSIZE: c.kind = PFX_OPSIZE;
			BYTE_ADSIZE: c.kind = PFX_ADSIZE;
			BYTE_CS: begin
				c.kind = PFX_SEG;
				c.seg  = SEG_CS;
			end
			BYTE_DS: begin
				c.kind = PFX_SEG;
				c.seg  = SEG_DS;
			end
			BYTE_ES: begin
				c.kind = PFX_SEG;
				c.seg  = SEG_ES;
			end
			BYTE_SS: begin
				c.kind = PFX_SEG;
				c.seg  = SEG_SS;
			end
			BYTE_FS: begin
				c.kind = PFX_SEG;
				c.seg  = SEG_FS;
			end
			BYTE_GS: begin
				c.kind = PFX_SEG;
				c.seg  = SEG_GS;
			end
			BYTE_REPNE: c.kind = PFX_REPNE;
			BYTE_REPE:  c.kind = PFX_REPE;
			default:    c.kind = PFX_NONE;
		endcase
		return c;
	endfunction

endpackage

[rtl/core/xpd_in_reg.sv]
module xpd_in_reg
	import xpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              code_valid,
	input  logic [CODE_W-1:0] code_byte,
	output logic              code_stall,
	input  logic              advance,
	output stage_t            stage
);

	logic              valid_s1;
	logic [CODE_W-1:0] code_s1;

	assign code_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!code_stall) begin
			valid_s1 <= code_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (code_valid && !code_stall) begin
			code_s1 <= code_byte;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.code  = code_s1;

endmodule

[rtl/core/xpd_core.sv]
`include "x86_prefix_decoder_defines.svh"

module xpd_core
	import xpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  stage_t             stage,
	output logic               advance,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [SEG_W-1:0]   segment_index,
	output logic               rep_equal,
	output logic               rep_not_equal,
	output logic               operand_wide,
	output logic               address_wide,
	output logic [COUNT_W-1:0] prefix_total,
	output logic [CODE_W-1:0]  opcode_byte,
	output logic               too_long
);

	logic               pmode_q;
	logic [SEG_W-1:0]   seg_q;
	logic               repe_q;
	logic               repne_q;
	logic               opsize_q;
	logic               adsize_q;
	logic [COUNT_W-1:0] count_q;
	logic               out_valid_q;

	prefix_class_t      cls;
	logic               is_prefix;
	logic               overflow;
	logic               emit;
	logic               out_free;
	logic               fire;
	logic [SEG_W-1:0]   seg_nx;
	logic               repe_nx;
	logic               repne_nx;
	logic               opsize_nx;
	logic               adsize_nx;
	logic [COUNT_W:0]   count_inc;
	logic [COUNT_W-1:0] total_sat;

	assign cls       = classify(stage.code);
	assign is_prefix = (cls.kind != PFX_NONE);
	assign overflow  = is_prefix && (count_q >= MAX_PREFIXES);
	assign emit      = !is_prefix || overflow;
	assign out_free  = !out_valid_q || !result_stall;
	assign advance   = !emit || out_free;
	assign fire      = stage.valid && advance;

	assign seg_nx    = (cls.kind == PFX_SEG) ? cls.seg : seg_q;
	assign repe_nx   = repe_q   || (cls.kind == PFX_REPE);
	assign repne_nx  = repne_q  || (cls.kind == PFX_REPNE);
	assign opsize_nx = opsize_q || (cls.kind == PFX_OPSIZE);
	assign adsize_nx = adsize_q || (cls.kind == PFX_ADSIZE);
	assign count_inc = {1'b0, count_q} + {{COUNT_W{1'b0}}, 1'b1};
	assign total_sat = count_inc[COUNT_W] ? COUNT_SAT : count_inc[COUNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			pmode_q <= cfg_wr_data;
		end
	end

	// Collect the prefix run; clear it once a result is made.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q    <= SEG_DS;
			repe_q   <= 1'b0;
			repne_q  <= 1'b0;
			opsize_q <= 1'b0;
			adsize_q <= 1'b0;
			count_q  <= '0;
		end else if (fire) begin
			if (emit) begin
				seg_q    <= SEG_DS;
				repe_q   <= 1'b0;
				repne_q  <= 1'b0;
				opsize_q <= 1'b0;
				adsize_q <= 1'b0;
				count_q  <= '0;
			end else begin
				seg_q    <= seg_nx;
				repe_q   <= repe_nx;
				repne_q  <= repne_nx;
				opsize_q <= opsize_nx;
				adsize_q <= adsize_nx;
				count_q  <= count_inc[COUNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			segment_index <= seg_nx;
			rep_equal     <= repe_nx;
			rep_not_equal <= repne_nx;
			operand_wide  <= pmode_q ^ opsize_nx;
			address_wide  <= pmode_q ^ adsize_nx;
			prefix_total  <= overflow ? total_sat : count_q;
			opcode_byte   <= stage.code;
			too_long      <= overflow;
		end
	end

	assign result_valid = out_valid_q;

	`XPD_ASSERT_NOW(a_count_bound, 1'b1, count_q <= MAX_PREFIXES, "prefix count past bound")
	`XPD_ASSERT_NEXT(a_clear_after_emit, fire && emit,
		count_q == '0 && seg_q == SEG_DS && !repe_q && !repne_q, "run not cleared")
	`XPD_ASSERT_NOW(a_long_total, out_valid_q && too_long,
		prefix_total >= MAX_PREFIXES, "short total on overlong run")
	`XPD_ASSERT_NOW(a_norm_total, out_valid_q && !too_long,
		prefix_total <= MAX_PREFIXES, "total past bound on normal result")
	`XPD_ASSERT_NEXT(a_emit_loads, fire && emit, out_valid_q, "result lost")

endmodule

[rtl/core/x86_prefix_decoder.sv]
// x86 instruction prefix decoder.
// Code channel: code_valid / code_stall carry one code_byte per item.
// Result channel: result_valid / result_stall carry one decoded instruction
// head per item, made when a non-prefix byte ends a prefix run, or early with
// too_long set when the run grows past MAX_PREFIXES prefix bytes.
// Prefix bytes within the bound make no result; they only update the run.
// protected_mode is written through cfg_wr_en / cfg_wr_data; it sets the
// default operand and address size and applies from the next item on.
// A result passes the input register, then the result register, after its
// ending byte is accepted. Throughput: one byte per cycle unless code_stall
// holds; the classify and flag update logic sits between the two registers.
// When result_stall holds, the result register keeps its item, the input
// register still drains prefix bytes, and code_stall rises only once a byte
// that needs a result slot waits there.
// Reset clears both registers' valid flags, the prefix run and
// protected_mode; the block takes items as soon as reset is released.
module x86_prefix_decoder
	import xpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic               code_valid,
	output logic               code_stall,
	input  logic [CODE_W-1:0]  code_byte,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [SEG_W-1:0]   segment_index,
	output logic               rep_equal,
	output logic               rep_not_equal,
	output logic               operand_wide,
	output logic               address_wide,
	output logic [COUNT_W-1:0] prefix_total,
	output logic [CODE_W-1:0]  opcode_byte,
	output logic               too_long
);

	stage_t stage;
	logic   advance;

	xpd_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code_valid),
		.code_byte  (code_byte),
		.code_stall (code_stall),
		.advance    (advance),
		.stage      (stage)
	);

	xpd_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.stage         (stage),
		.advance       (advance),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.segment_index (segment_index),
		.rep_equal     (rep_equal),
		.rep_not_equal (rep_not_equal),
		.operand_wide  (operand_wide),
		.address_wide  (address_wide),
		.prefix_total  (prefix_total),
		.opcode_byte   (opcode_byte),
		.too_long      (too_long)
	);

endmodule

[bench/tb_x86_prefix_decoder.sv]
`timescale 1ns / 100ps

import xpd_pkg::*;

typedef struct packed {
	logic [SEG_W-1:0]   segment_index;
	logic               rep_equal;
	logic               rep_not_equal;
	logic               operand_wide;
	logic               address_wide;
	logic [COUNT_W-1:0] prefix_total;
	logic [CODE_W-1:0]  opcode_byte;
	logic               too_long;
} instr_head_t;

class prefix_run_tracker;
	instr_head_t        expected_heads[$];
	bit                 protected_mode;
	logic [SEG_W-1:0]   seg_choice;
	bit                 repe_seen;
	bit                 repne_seen;
	bit                 opsize_seen;
	bit                 adsize_seen;
	logic [COUNT_W-1:0] run_count;
	int                 errors;

	function new();
		protected_mode = 1'b0;
		errors = 0;
		clear_run();
	endfunction

	function void clear_run();
		seg_choice = SEG_DS;
		repe_seen = 1'b0;
		repne_seen = 1'b0;
		opsize_seen = 1'b0;
		adsize_seen = 1'b0;
		run_count = '0;
	endfunction

	function int pending();
		return expected_heads.size();
	endfunction

	function void take_byte(logic [CODE_W-1:0] b);
		instr_head_t head;
		bit is_prefix;
		is_prefix = 1'b1;
		case (b)
			BYTE_OPSIZE: opsize_seen = 1'b1;
			BYTE_ADSIZE: adsize_seen = 1'b1;
			BYTE_CS:     seg_choice = SEG_CS;
			BYTE_DS:     seg_choice = SEG_DS;
			BYTE_ES:     seg_choice = SEG_ES;
			BYTE_SS:     seg_choice = SEG_SS;
			BYTE_FS:     seg_choice = SEG_FS;
			BYTE_GS:     seg_choice = SEG_GS;
			BYTE_REPNE:  repne_seen = 1'b1;
			BYTE_REPE:   repe_seen = 1'b1;
			default:     is_prefix = 1'b0;
		endcase
		if (is_prefix && run_count < MAX_PREFIXES) begin
			run_count = run_count + 1'b1;
			return;
		end
		head.segment_index = seg_choice;
		head.rep_equal = repe_seen;
		head.rep_not_equal = repne_seen;
		head.operand_wide = protected_mode ^ opsize_seen;
		head.address_wide = protected_mode ^ adsize_seen;
		if (!is_prefix)
			head.prefix_total = run_count;
		else if (run_count == COUNT_SAT)
			head.prefix_total = COUNT_SAT;
		else
			head.prefix_total = run_count + 1'b1;
		head.opcode_byte = b;
		head.too_long = is_prefix;
		expected_heads.push_back(head);
		clear_run();
	endfunction

	function void compare(string field, logic [7:0] want, logic [7:0] seen);
		if (want !== seen) begin
			$error("%s: expected %0h, got %0h", field, want, seen);
			errors++;
		end
	endfunction

	function void check_head(instr_head_t got);
		instr_head_t want;
		if (expected_heads.size() == 0) begin
			$error("result with no item pending: opcode_byte %0h", got.opcode_byte);
			errors++;
			return;
		end
		want = expected_heads.pop_front();
		compare("segment_index", want.segment_index, got.segment_index);
		compare("rep_equal", want.rep_equal, got.rep_equal);
		compare("rep_not_equal", want.rep_not_equal, got.rep_not_equal);
		compare("operand_wide", want.operand_wide, got.operand_wide);
		compare("address_wide", want.address_wide, got.address_wide);
		compare("prefix_total", want.prefix_total, got.prefix_total);
		compare("opcode_byte", want.opcode_byte, got.opcode_byte);
		compare("too_long", want.too_long, got.too_long);
	endfunction
endclass

module tb_x86_prefix_decoder;
	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic               cfg_wr_data;
	logic               code_valid;
	logic               code_stall;
	logic [CODE_W-1:0]  code_byte;
	logic               result_valid;
	logic               result_stall;
	logic [SEG_W-1:0]   segment_index;
	logic               rep_equal;
	logic               rep_not_equal;
	logic               operand_wide;
	logic               address_wide;
	logic [COUNT_W-1:0] prefix_total;
	logic [CODE_W-1:0]  opcode_byte;
	logic               too_long;

	prefix_run_tracker run_tracker = new();
	bit gap_on;
	bit stall_on;
	int hold_cycles;
	int phase_bytes;

	x86_prefix_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code_byte(code_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.segment_index(segment_index),
		.rep_equal(rep_equal),
		.rep_not_equal(rep_not_equal),
		.operand_wide(operand_wide),
		.address_wide(address_wide),
		.prefix_total(prefix_total),
		.opcode_byte(opcode_byte),
		.too_long(too_long)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// receive side: random stall, long hold on request
	initial begin
		instr_head_t got;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) begin
				got = {segment_index, rep_equal, rep_not_equal, operand_wide,
					address_wide, prefix_total, opcode_byte, too_long};
				run_tracker.check_head(got);
			end
			if (hold_cycles > 0) begin
				result_stall <= 1'b1;
				hold_cycles--;
			end else begin
				result_stall <= stall_on && ($urandom_range(99) < 32);
			end
		end
	end

	task automatic send_byte(input logic [CODE_W-1:0] b);
		while (gap_on && $urandom_range(99) < 32) begin
			code_valid <= 1'b0;
			@(posedge clk);
		end
		code_valid <= 1'b1;
		code_byte <= b;
		do @(posedge clk); while (code_stall);
		run_tracker.take_byte(b);
		phase_bytes++;
	endtask

	task automatic drain_results();
		code_valid <= 1'b0;
		while (run_tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mode(input bit mode);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= mode;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		run_tracker.protected_mode = mode;
	endtask

	function automatic logic [CODE_W-1:0] pick_prefix();
		case ($urandom_range(9))
			0: return BYTE_OPSIZE;
			1: return BYTE_ADSIZE;
			2: return BYTE_CS;
			3: return BYTE_DS;
			4: return BYTE_ES;
			5: return BYTE_SS;
			6: return BYTE_FS;
			7: return BYTE_GS;
			8: return BYTE_REPNE;
			default: return BYTE_REPE;
		endcase
	endfunction

	task automatic send_instr();
		int n;
		n = ($urandom_range(9) == 0) ? $urandom_range(13, 16) : $urandom_range(0, 4);
		repeat (n) send_byte(pick_prefix());
		send_byte(CODE_W'($urandom_range(255)));
	endtask

	task automatic random_phase(input int count);
		phase_bytes = 0;
		while (phase_bytes < count) begin
			if ($urandom_range(99) < 85)
				send_instr();
			else
				send_byte(CODE_W'($urandom_range(255)));
		end
	endtask

	initial begin
		logic [CODE_W-1:0] directed[$];
		bit modes[6];
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= 1'b0;
		code_valid <= 1'b0;
		code_byte <= '0;
		gap_on = 1'b1;
		stall_on = 1'b1;
		hold_cycles = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// overlong run covering every prefix, then short runs
		directed = '{BYTE_OPSIZE, BYTE_ADSIZE, BYTE_CS, BYTE_ES, BYTE_SS, BYTE_FS,
			BYTE_GS, BYTE_DS, BYTE_REPNE, BYTE_REPE, BYTE_OPSIZE, BYTE_REPE,
			BYTE_CS, BYTE_ES, BYTE_SS,
			8'h00, BYTE_OPSIZE, 8'h90, BYTE_ADSIZE, BYTE_FS, 8'hff,
			BYTE_REPNE, BYTE_REPE, 8'ha6, BYTE_CS, BYTE_DS, 8'h8b};
		foreach (directed[i])
			send_byte(directed[i]);
		drain_results();

		modes = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
		foreach (modes[p]) begin
			write_mode(modes[p]);
			gap_on = (p != 1);
			stall_on = (p != 1);
			if (p == 2)
				hold_cycles = 150;
			random_phase(70);
			drain_results();
		end

		if (run_tracker.errors == 0 && run_tracker.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
